[hw/rtl/ftu_pkg.sv]
`default_nettype none
package ftu_pkg;

	localparam int BUCKETS_DEF = 1024;
	localparam int WAYS_DEF = 4;
	localparam logic [31:0] CRC_POLY = 32'h82F63B78;
	localparam logic [7:0] TCP_PROTO = 8'd6;
	localparam logic [4:0] CRC_LAST_STEP = 5'd19;
	localparam logic [4:0] MOD_LAST_STEP = 5'd2;

	typedef enum logic [1:0] {
		STAT_UPDATED = 2'd0,
		STAT_NEW = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [11:0] vlan;
		logic [7:0] protocol;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0] tos_acc;
		logic [7:0] flags_acc;
		logic [63:0] byte_count;
		logic [63:0] packet_count;
		logic [31:0] first_seen;
		logic [31:0] last_seen;
	} entry_t;

	typedef struct packed {
		logic clr_step;
		logic load_in;
		logic crc_step;
		logic mod_step;
		logic rd;
		logic upd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic crc_last;
		logic mod_last;
		logic out_free;
	} sts_t;

	// reflected crc32c, one byte lsb first
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/ftu_ctrl.sv]
`default_nettype none
module ftu_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pkt_valid,
	output logic pkt_stall,
	input wire ftu_pkg::sts_t sts,
	output ftu_pkg::cmd_t cmd
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_CRC = 7'b0000100,
		S_MOD = 7'b0001000,
		S_READ = 7'b0010000,
		S_UPD = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign pkt_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (pkt_valid) begin
					cmd.load_in = 1'b1;
					state_nxt = S_CRC;
				end
			end
			S_CRC: begin
				cmd.crc_step = 1'b1;
				if (sts.crc_last) state_nxt = S_MOD;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) state_nxt = S_READ;
			end
			S_READ: begin
				cmd.rd = 1'b1;
				state_nxt = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[hw/rtl/ftu_dp.sv]
`default_nettype none
module ftu_dp #(
	parameter int BUCKETS = ftu_pkg::BUCKETS_DEF,
	parameter int WAYS = ftu_pkg::WAYS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire ftu_pkg::cmd_t cmd,
	output ftu_pkg::sts_t sts,
	input wire logic [11:0] vlan_id,
	input wire logic [7:0] protocol,
	input wire logic [31:0] src_addr,
	input wire logic [31:0] dst_addr,
	input wire logic [15:0] l4_sport,
	input wire logic [15:0] l4_dport,
	input wire logic [7:0] tos,
	input wire logic [7:0] tcp_flag_bits,
	input wire logic [15:0] ip_len,
	input wire logic [31:0] now_time,
	output logic res_valid,
	input wire logic res_stall,
	output logic [1:0] status,
	output logic [9:0] bucket_index,
	output logic [1:0] way_index,
	output logic [63:0] flow_bytes,
	output logic [63:0] flow_packets
);

	localparam int BKW = $clog2(BUCKETS);
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [31:0] BUCKETS_32 = 32'(BUCKETS);
	localparam logic [63:0] RECIP_FULL = (64'd1 << (31 + BKW)) / 64'(BUCKETS);
	localparam logic [31:0] RECIP = RECIP_FULL[31:0];
	localparam logic [BKW-1:0] LAST_ROW = BKW'(BUCKETS - 1);

	// latched packet
	logic [11:0] vlan_q;
	logic [7:0] proto_q;
	logic [31:0] saddr_q, daddr_q;
	logic [15:0] sport_q, dport_q;
	logic [7:0] tos_q, flags_q;
	logic [15:0] len_q;
	logic [31:0] now_q;

	logic [4:0] crc_cnt_q;
	logic [31:0] crc_q;
	logic [4:0] mod_cnt_q;
	logic [63:0] prod_q;
	logic [31:0] diff_q;
	logic [BKW-1:0] rem_q;
	logic [BKW-1:0] clr_cnt_q;

	ftu_pkg::entry_t [WAYS-1:0] row_mem [BUCKETS];
	logic [WAYS-1:0] vld_mem [BUCKETS];
	ftu_pkg::entry_t [WAYS-1:0] row_rd_q;
	logic [WAYS-1:0] vld_rd_q;

	logic [31:0] crc_word;
	logic [7:0] crc_in;
	logic [31:0] quot;

	logic hit_f, free_f;
	logic [WW-1:0] hit_w, free_w, sel_w;
	ftu_pkg::entry_t ent_new;
	ftu_pkg::entry_t [WAYS-1:0] row_new;
	logic [WAYS-1:0] vld_new;
	logic row_we;
	logic vld_we;
	logic [BKW-1:0] vld_wa;
	logic [WAYS-1:0] vld_wd;

	ftu_pkg::status_t res_stat_q;
	logic [WW-1:0] res_way_q;
	logic [63:0] res_bytes_q, res_pkts_q;
	logic [31:0] bkt32, way32;
	logic out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			vlan_q <= vlan_id;
			proto_q <= protocol;
			saddr_q <= src_addr;
			daddr_q <= dst_addr;
			sport_q <= l4_sport;
			dport_q <= l4_dport;
			tos_q <= tos;
			flags_q <= tcp_flag_bits;
			len_q <= ip_len;
			now_q <= now_time;
		end
	end

	// key words fed protocol, src, dst, sport, dport
	always_comb begin
		case (crc_cnt_q[4:2])
			3'd0: crc_word = {24'd0, proto_q};
			3'd1: crc_word = saddr_q;
			3'd2: crc_word = daddr_q;
			3'd3: crc_word = {16'd0, sport_q};
			3'd4: crc_word = {16'd0, dport_q};
			default: crc_word = '0;
		endcase
		crc_in = crc_word[{crc_cnt_q[1:0], 3'b000} +: 8];
		// quotient estimate, exact or one short
		quot = 32'(prod_q >> (31 + BKW));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_cnt_q <= '0;
			mod_cnt_q <= '0;
			clr_cnt_q <= '0;
			crc_q <= '0;
			prod_q <= '0;
			diff_q <= '0;
			rem_q <= '0;
		end else begin
			if (cmd.load_in) begin
				crc_cnt_q <= '0;
				mod_cnt_q <= '0;
				crc_q <= '0;
				rem_q <= '0;
			end
			if (cmd.crc_step) begin
				crc_cnt_q <= crc_cnt_q + 5'd1;
				crc_q <= ftu_pkg::crc_byte(crc_q, crc_in);
			end
			// remainder: reciprocal multiply, multiply-subtract, one correction
			if (cmd.mod_step) begin
				mod_cnt_q <= mod_cnt_q + 5'd1;
				if (mod_cnt_q == 5'd0) begin
					prod_q <= 64'(crc_q) * 64'(RECIP);
				end else if (mod_cnt_q == 5'd1) begin
					diff_q <= crc_q - quot * BUCKETS_32;
				end else begin
					rem_q <= (diff_q >= BUCKETS_32) ? BKW'(diff_q - BUCKETS_32) : BKW'(diff_q);
				end
			end
			if (cmd.clr_step) clr_cnt_q <= clr_cnt_q + BKW'(1);
		end
	end

	// way lookup, lowest match wins then lowest free way
	always_comb begin
		hit_f = 1'b0;
		free_f = 1'b0;
		hit_w = '0;
		free_w = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (vld_rd_q[w] && row_rd_q[w].src_addr == saddr_q
					&& row_rd_q[w].dst_addr == daddr_q) begin
				hit_f = 1'b1;
				hit_w = WW'(w);
			end
			if (!vld_rd_q[w]) begin
				free_f = 1'b1;
				free_w = WW'(w);
			end
		end
		sel_w = hit_f ? hit_w : free_w;
		ent_new = row_rd_q[sel_w];
		if (hit_f) begin
			ent_new.tos_acc = ent_new.tos_acc | tos_q;
			if (proto_q == ftu_pkg::TCP_PROTO) ent_new.flags_acc = ent_new.flags_acc | flags_q;
			ent_new.byte_count = ent_new.byte_count + {48'd0, len_q};
			ent_new.packet_count = ent_new.packet_count + 64'd1;
			ent_new.last_seen = now_q;
		end else begin
			ent_new.vlan = vlan_q;
			ent_new.protocol = proto_q;
			ent_new.src_addr = saddr_q;
			ent_new.dst_addr = daddr_q;
			ent_new.src_port = sport_q;
			ent_new.dst_port = dport_q;
			ent_new.tos_acc = tos_q;
			ent_new.flags_acc = (proto_q == ftu_pkg::TCP_PROTO) ? flags_q : 8'd0;
			ent_new.byte_count = {48'd0, len_q};
			ent_new.packet_count = 64'd1;
			ent_new.first_seen = now_q;
			ent_new.last_seen = now_q;
		end
		row_new = row_rd_q;
		row_new[sel_w] = ent_new;
		vld_new = vld_rd_q;
		vld_new[sel_w] = 1'b1;
	end

	assign row_we = cmd.upd & (hit_f | free_f);
	assign vld_we = cmd.clr_step | row_we;
	assign vld_wa = cmd.clr_step ? clr_cnt_q : rem_q;
	assign vld_wd = cmd.clr_step ? '0 : vld_new;

	always_ff @(posedge clk) begin
		if (vld_we) vld_mem[vld_wa] <= vld_wd;
		if (cmd.rd) vld_rd_q <= vld_mem[rem_q];
	end

	always_ff @(posedge clk) begin
		if (row_we) row_mem[rem_q] <= row_new;
		if (cmd.rd) row_rd_q <= row_mem[rem_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			if (hit_f || free_f) begin
				res_stat_q <= hit_f ? ftu_pkg::STAT_UPDATED : ftu_pkg::STAT_NEW;
				res_way_q <= sel_w;
				res_bytes_q <= ent_new.byte_count;
				res_pkts_q <= ent_new.packet_count;
			end else begin
				res_stat_q <= ftu_pkg::STAT_FULL;
				res_way_q <= '0;
				res_bytes_q <= '0;
				res_pkts_q <= '0;
			end
		end
	end

	assign bkt32 = 32'(rem_q);
	assign way32 = 32'(res_way_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status <= res_stat_q;
			bucket_index <= bkt32[9:0];
			way_index <= way32[1:0];
			flow_bytes <= res_bytes_q;
			flow_packets <= res_pkts_q;
		end
	end

	assign res_valid = out_valid_q;

	assign sts.clr_last = (clr_cnt_q == LAST_ROW);
	assign sts.crc_last = (crc_cnt_q == ftu_pkg::CRC_LAST_STEP);
	assign sts.mod_last = (mod_cnt_q == ftu_pkg::MOD_LAST_STEP);
	assign sts.out_free = ~out_valid_q | ~res_stall;

endmodule
`default_nettype wire

[hw/rtl/flow_table_update_core.sv]
// flow cache update core
// packet channel: pkt_valid / pkt_stall carry one packet's key and header
// fields; a transaction completes on a rising edge with valid high and stall low
// result channel: res_valid / res_stall carry status, bucket, way and the
// flow's byte and packet counts after the packet, or zeros when the bucket is full
// each packet is hashed with crc32c one byte per cycle, reduced
// modulo BUCKETS by a reciprocal multiply, a multiply-subtract and one
// compare-subtract, then the bucket row is read, updated and written back,
// and the result goes to the output register
// one packet is in flight at a time; pkt_stall is high while it is worked on
// a result waiting in the output register under res_stall holds back the
// next packet's result, and with it pkt_stall, until the register frees
// after reset the valid bits are swept, one bucket per cycle, with pkt_stall
// high; flow contents themselves are not cleared
// counters wrap modulo 2^64
`default_nettype none
module flow_table_update_core #(
	parameter int BUCKETS = ftu_pkg::BUCKETS_DEF,
	parameter int WAYS = ftu_pkg::WAYS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pkt_valid,
	output logic pkt_stall,
	input wire logic [11:0] vlan_id,
	input wire logic [7:0] protocol,
	input wire logic [31:0] src_addr,
	input wire logic [31:0] dst_addr,
	input wire logic [15:0] l4_sport,
	input wire logic [15:0] l4_dport,
	input wire logic [7:0] tos,
	input wire logic [7:0] tcp_flag_bits,
	input wire logic [15:0] ip_len,
	input wire logic [31:0] now_time,
	output logic res_valid,
	input wire logic res_stall,
	output logic [1:0] status,
	output logic [9:0] bucket_index,
	output logic [1:0] way_index,
	output logic [63:0] flow_bytes,
	output logic [63:0] flow_packets
);

	// command and status between sequencer and datapath
	ftu_pkg::cmd_t cmd;
	ftu_pkg::sts_t sts;

	ftu_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.sts(sts),
		.cmd(cmd)
	);

	// hash, remainder, bucket memory and output register
	ftu_dp #(
		.BUCKETS(BUCKETS),
		.WAYS(WAYS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.vlan_id(vlan_id),
		.protocol(protocol),
		.src_addr(src_addr),
		.dst_addr(dst_addr),
		.l4_sport(l4_sport),
		.l4_dport(l4_dport),
		.tos(tos),
		.tcp_flag_bits(tcp_flag_bits),
		.ip_len(ip_len),
		.now_time(now_time),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.bucket_index(bucket_index),
		.way_index(way_index),
		.flow_bytes(flow_bytes),
		.flow_packets(flow_packets)
	);

endmodule
`default_nettype wire

[hw/rtl/ftu_checker.sv]
`default_nettype none
module ftu_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pkt_valid,
	input wire logic pkt_stall,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire logic [1:0] status,
	input wire logic [1:0] way_index,
	input wire logic [63:0] flow_bytes,
	input wire logic [63:0] flow_packets
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_busy_after_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && !pkt_stall |=> pkt_stall)
		else $error("second packet taken while one is in flight");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ftu_pkg::STAT_FULL |->
		way_index == 2'd0 && flow_bytes == 64'd0 && flow_packets == 64'd0)
		else $error("dropped packet reports nonzero fields");

	a_new_one_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ftu_pkg::STAT_NEW |-> flow_packets == 64'd1)
		else $error("new flow packet count not one");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status == ftu_pkg::STAT_UPDATED || status == ftu_pkg::STAT_NEW
		|| status == ftu_pkg::STAT_FULL)
		else $error("unknown status code");

endmodule

bind flow_table_update_core ftu_checker u_ftu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.pkt_valid(pkt_valid),
	.pkt_stall(pkt_stall),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.status(status),
	.way_index(way_index),
	.flow_bytes(flow_bytes),
	.flow_packets(flow_packets)
);
`default_nettype wire

[bench/tb_flow_table_update_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_flow_table_update_core;

	localparam int BUCKETS = ftu_pkg::BUCKETS_DEF;
	localparam int WAYS = ftu_pkg::WAYS_DEF;
	localparam int RANDOM_PACKETS = 800;

	// expected result of one packet
	typedef struct {
		ftu_pkg::status_t st;
		logic [9:0] bucket;
		logic [1:0] way;
		logic [63:0] bytes;
		logic [63:0] packets;
	} flow_result_t;

	// flow cache shadow plus queue of pending results
	class flow_cache_board;
		bit valid_q[BUCKETS*WAYS];
		logic [31:0] saddr_q[BUCKETS*WAYS];
		logic [31:0] daddr_q[BUCKETS*WAYS];
		logic [7:0] tos_q[BUCKETS*WAYS];
		logic [7:0] flags_q[BUCKETS*WAYS];
		logic [63:0] bytes_q[BUCKETS*WAYS];
		logic [63:0] pkts_q[BUCKETS*WAYS];
		logic [31:0] last_q[BUCKETS*WAYS];
		flow_result_t pending[$];
		int mismatches;

		function logic [31:0] crc_word(logic [31:0] crc, logic [31:0] w);
			crc = crc ^ w;
			for (int b = 0; b < 32; b++)
				crc = crc[0] ? ((crc >> 1) ^ ftu_pkg::CRC_POLY) : (crc >> 1);
			return crc;
		endfunction

		function logic [9:0] bucket_of(logic [7:0] p, logic [31:0] s, logic [31:0] d,
				logic [15:0] sp, logic [15:0] dp);
			logic [31:0] h;
			h = crc_word(32'd0, {24'd0, p});
			h = crc_word(h, s);
			h = crc_word(h, d);
			h = crc_word(h, {16'd0, sp});
			h = crc_word(h, {16'd0, dp});
			return 10'(h % BUCKETS);
		endfunction

		// apply one accepted packet to the shadow table
		function void note_packet(logic [7:0] p, logic [31:0] s, logic [31:0] d,
				logic [15:0] sp, logic [15:0] dp, logic [7:0] t, logic [7:0] f,
				logic [15:0] len, logic [31:0] now);
			flow_result_t r;
			int hit, fw, base, k;
			hit = -1;
			fw = -1;
			r.bucket = bucket_of(p, s, d, sp, dp);
			base = r.bucket * WAYS;
			for (int w = 0; w < WAYS; w++) begin
				if (valid_q[base+w]) begin
					if (hit < 0 && saddr_q[base+w] == s && daddr_q[base+w] == d) hit = w;
				end else if (fw < 0) fw = w;
			end
			r.way = '0;
			r.bytes = '0;
			r.packets = '0;
			if (hit >= 0) begin
				k = base + hit;
				tos_q[k] |= t;
				if (p == ftu_pkg::TCP_PROTO) flags_q[k] |= f;
				bytes_q[k] += {48'd0, len};
				pkts_q[k] += 64'd1;
				last_q[k] = now;
				r.st = ftu_pkg::STAT_UPDATED;
				r.way = 2'(hit);
				r.bytes = bytes_q[k];
				r.packets = pkts_q[k];
			end else if (fw >= 0) begin
				k = base + fw;
				valid_q[k] = 1'b1;
				saddr_q[k] = s;
				daddr_q[k] = d;
				tos_q[k] = t;
				flags_q[k] = (p == ftu_pkg::TCP_PROTO) ? f : 8'd0;
				bytes_q[k] = {48'd0, len};
				pkts_q[k] = 64'd1;
				last_q[k] = now;
				r.st = ftu_pkg::STAT_NEW;
				r.way = 2'(fw);
				r.bytes = {48'd0, len};
				r.packets = 64'd1;
			end else r.st = ftu_pkg::STAT_FULL;
			pending.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [9:0] b, logic [1:0] w,
				logic [63:0] by, logic [63:0] pk);
			flow_result_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result status=%0d bucket=%0d", st, b);
				return;
			end
			e = pending.pop_front();
			if (st !== e.st || b !== e.bucket || w !== e.way || by !== e.bytes
					|| pk !== e.packets) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result differs: exp st=%0d b=%0d w=%0d by=%0d pk=%0d",
						e.st, e.bucket, e.way, e.bytes, e.packets);
					$display("                got st=%0d b=%0d w=%0d by=%0d pk=%0d",
						st, b, w, by, pk);
				end
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic pkt_valid, pkt_stall;
	logic [11:0] vlan_id;
	logic [7:0] protocol, tos, tcp_flag_bits;
	logic [31:0] src_addr, dst_addr, now_time;
	logic [15:0] l4_sport, l4_dport, ip_len;
	logic res_valid, res_stall;
	logic [1:0] status, way_index;
	logic [9:0] bucket_index;
	logic [63:0] flow_bytes, flow_packets;

	flow_cache_board board;
	bit sending_done;
	bit hold_off_active;
	// small pool of address pairs so flows recur and buckets see hits
	logic [31:0] pool_s[16], pool_d[16];

	flow_table_update_core uut (
		.clk(clk), .arst_n(arst_n),
		.pkt_valid(pkt_valid), .pkt_stall(pkt_stall),
		.vlan_id(vlan_id), .protocol(protocol), .src_addr(src_addr), .dst_addr(dst_addr),
		.l4_sport(l4_sport), .l4_dport(l4_dport), .tos(tos), .tcp_flag_bits(tcp_flag_bits),
		.ip_len(ip_len), .now_time(now_time),
		.res_valid(res_valid), .res_stall(res_stall),
		.status(status), .bucket_index(bucket_index), .way_index(way_index),
		.flow_bytes(flow_bytes), .flow_packets(flow_packets)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// send one packet transaction, after an optional gap with valid low
	// valid stays up after the transaction until the next call drops or reuses it
	task automatic send_packet(logic [11:0] v, logic [7:0] p, logic [31:0] s,
			logic [31:0] d, logic [15:0] sp, logic [15:0] dp, logic [7:0] t,
			logic [7:0] f, logic [15:0] len, logic [31:0] now, int gap);
		if (gap > 0) begin
			pkt_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		pkt_valid <= 1;
		vlan_id <= v;
		protocol <= p;
		src_addr <= s;
		dst_addr <= d;
		l4_sport <= sp;
		l4_dport <= dp;
		tos <= t;
		tcp_flag_bits <= f;
		ip_len <= len;
		now_time <= now;
		// wait for the transaction edge
		do @(posedge clk); while (pkt_stall);
		board.note_packet(p, s, d, sp, dp, t, f, len, now);
	endtask

	// random packet: mostly recurring flows, some fresh noise
	task automatic send_random(int gap);
		int i;
		logic [31:0] s, d;
		logic [7:0] p;
		i = $urandom_range(0, 15);
		s = pool_s[i];
		d = pool_d[i];
		if ($urandom_range(0, 3) == 0) begin
			s = $urandom;
			d = $urandom;
		end
		p = ($urandom_range(0, 1)) ? ftu_pkg::TCP_PROTO : 8'($urandom);
		send_packet(12'($urandom), p, s, d, 16'($urandom), 16'($urandom),
			8'($urandom), 8'($urandom), 16'($urandom), $urandom, gap);
	endtask

	// find four address pairs that land in one bucket, plus a fifth for overflow, and send each
	task automatic fill_one_bucket();
		logic [9:0] target;
		logic [31:0] s;
		int found;
		found = 0;
		target = board.bucket_of(8'd17, 32'h0, 32'h0, 16'd0, 16'd0);
		s = 32'd1;
		while (found < WAYS + 1) begin
			if (board.bucket_of(8'd17, s, 32'h0, 16'd0, 16'd0) == target) begin
				send_packet(12'd5, 8'd17, s, 32'h0, 16'd0, 16'd0, 8'h0f, 8'hff,
					16'd100, 32'd7, 0);
				found++;
			end
			s++;
		end
	endtask

	initial begin
		board = new();
		arst_n = 0;
		pkt_valid = 0;
		vlan_id = 0; protocol = 0; src_addr = 0; dst_addr = 0;
		l4_sport = 0; l4_dport = 0; tos = 0; tcp_flag_bits = 0;
		ip_len = 0; now_time = 0;
		sending_done = 0;
		hold_off_active = 0;
		for (int i = 0; i < 16; i++) begin
			pool_s[i] = $urandom;
			pool_d[i] = $urandom;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, tcp vs non-tcp, repeated hits, full bucket
		send_packet(12'hfff, 8'hff, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff,
			8'hff, 8'hff, 16'hffff, 32'hffffffff, 0);
		send_packet(12'h000, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 8'h0, 16'h0, 32'h0, 0);
		send_packet(12'h000, 8'hff, 32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff,
			8'h00, 8'h00, 16'hffff, 32'd1, 0);
		// tcp flow: flags accumulate
		send_packet(12'h123, ftu_pkg::TCP_PROTO, 32'h0a000001, 32'h0a000002, 16'd80,
			16'd443, 8'h10, 8'h02, 16'd60, 32'd100, 0);
		send_packet(12'h123, ftu_pkg::TCP_PROTO, 32'h0a000001, 32'h0a000002, 16'd80,
			16'd443, 8'h01, 8'h10, 16'd1500, 32'd200, 3);
		// same addresses, non-tcp: flags untouched, ports differ
		send_packet(12'h456, 8'd17, 32'h0a000001, 32'h0a000002, 16'd53, 16'd53,
			8'h20, 8'hff, 16'd40, 32'd300, 0);
		send_packet(12'h456, 8'd17, 32'h0a000001, 32'h0a000002, 16'd80, 16'd443,
			8'h20, 8'hff, 16'd40, 32'd301, 0);
		fill_one_bucket();

		// long receiver hold-off while packets keep coming
		hold_off_active = 1;
		for (int n = 0; n < 6; n++) send_random(0);
		hold_off_active = 0;

		for (int n = 0; n < RANDOM_PACKETS; n++)
			send_random(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
		pkt_valid <= 0;
		sending_done = 1;
	end

	// result side: random stalls, and long stretches of holding off while hold_off_active is set
	initial begin
		int wait_cycles;
		res_stall = 1;
		@(posedge arst_n);
		forever begin
			if (hold_off_active) begin
				res_stall <= 1;
				repeat (400) @(posedge clk);
			end
			wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
			if (wait_cycles > 0) begin
				res_stall <= 1;
				repeat (wait_cycles) @(posedge clk);
			end
			res_stall <= 0;
			do @(posedge clk); while (!res_valid);
			board.check_result(status, bucket_index, way_index, flow_bytes, flow_packets);
		end
	end

	// end of run once all results are in
	initial begin
		wait (sending_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// timeout: ~820 packets plus gaps and stalls, plus the sweep
	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
